@@ rtl/iefb_pkg.sv @@
// Package for the ICMP echo frame builder.
// Holds the cell type, the frame image type, the register indexes and the fixed header fields.
// No dependencies.
package iefb_pkg;

    localparam int FRAME_LEN = 42;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 48;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROUTER_MAC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_MAC    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_IP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_IP    = 3'd3;

    // Fixed header fields
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [7:0]  IP_TOS         = 8'h00;
    localparam logic [15:0] IP_TOTAL_LEN   = 16'h001C;
    localparam logic [15:0] IP_ID          = 16'h1234;
    localparam logic [15:0] IP_FLAGS_FRAG  = 16'h4000;
    localparam logic [7:0]  IP_TTL         = 8'h40;
    localparam logic [7:0]  IP_PROTO_ICMP  = 8'h01;
    localparam logic [7:0]  ICMP_TYPE_ECHO = 8'h08;
    localparam logic [7:0]  ICMP_CODE      = 8'h00;
    localparam logic [15:0] ICMP_CSUM      = 16'h8F53;
    localparam logic [15:0] ICMP_DATA_HI   = 16'h1234;
    localparam logic [15:0] ICMP_DATA_LO   = 16'h5678;

    // Sum of the fixed IPv4 header words (TTL and protocol form one word)
    localparam logic [15:0] IP_FIXED_SUM = IP_VER_IHL * 16'd256 + IP_TOTAL_LEN + IP_ID
                                         + IP_FLAGS_FRAG + IP_TTL * 16'd256 + IP_PROTO_ICMP;

    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    typedef struct packed {
        logic             vld;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
        logic             last;
    } cell_t;

endpackage

@@ rtl/iefb_image.sv @@
// Frame image for the ICMP echo frame builder: all 42 bytes of one frame in wire order.
// Computes the IPv4 header checksum from the configured addresses.
// Depends on iefb_pkg.
module iefb_image (
    input  logic [47:0]     router_mac,
    input  logic [47:0]     src_mac,
    input  logic [31:0]     src_ip,
    input  logic [31:0]     dest_ip,
    output iefb_pkg::frame_t image
);
    import iefb_pkg::*;

    logic [18:0] sum_raw;
    logic [16:0] sum_fold1;
    logic [16:0] sum_fold2;
    logic [15:0] ip_csum;

    // Ones' complement sum with end-around carry folded twice
    always_comb
    begin
        sum_raw   = 19'(IP_FIXED_SUM) + 19'(src_ip[31:16]) + 19'(src_ip[15:0])
                  + 19'(dest_ip[31:16]) + 19'(dest_ip[15:0]);
        sum_fold1 = 17'(sum_raw[18:16]) + 17'(sum_raw[15:0]);
        sum_fold2 = 17'(sum_fold1[16]) + 17'(sum_fold1[15:0]);
        ip_csum   = ~sum_fold2[15:0];
    end

    // image[i] is byte i on the wire
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            image[i]     = router_mac[8*(5-i) +: 8];
            image[6 + i] = src_mac[8*(5-i) +: 8];
        end
        image[12] = ETHERTYPE_IPV4[15:8];
        image[13] = ETHERTYPE_IPV4[7:0];
        image[14] = IP_VER_IHL;
        image[15] = IP_TOS;
        image[16] = IP_TOTAL_LEN[15:8];
        image[17] = IP_TOTAL_LEN[7:0];
        image[18] = IP_ID[15:8];
        image[19] = IP_ID[7:0];
        image[20] = IP_FLAGS_FRAG[15:8];
        image[21] = IP_FLAGS_FRAG[7:0];
        image[22] = IP_TTL;
        image[23] = IP_PROTO_ICMP;
        image[24] = ip_csum[15:8];
        image[25] = ip_csum[7:0];
        for (int i = 0; i < 4; i++)
        begin
            image[26 + i] = src_ip[8*(3-i) +: 8];
            image[30 + i] = dest_ip[8*(3-i) +: 8];
        end
        image[34] = ICMP_TYPE_ECHO;
        image[35] = ICMP_CODE;
        image[36] = ICMP_CSUM[15:8];
        image[37] = ICMP_CSUM[7:0];
        image[38] = ICMP_DATA_HI[15:8];
        image[39] = ICMP_DATA_HI[7:0];
        image[40] = ICMP_DATA_LO[15:8];
        image[41] = ICMP_DATA_LO[7:0];
    end

endmodule

@@ rtl/iefb_cell.sv @@
// One byte cell of the ICMP echo frame builder's output chain.
// Loads its byte of a new frame or takes the beat of its upstream neighbor.
// Depends on iefb_pkg.
module iefb_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                advance,
    input  iefb_pkg::cell_t     load_val,
    input  iefb_pkg::cell_t     from_up,
    output iefb_pkg::cell_t     slot
);
    import iefb_pkg::*;

    logic                 vld_reg;
    logic                 vld_next;
    logic [7:0]           data_reg;
    logic [7:0]           data_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 last_reg;
    logic                 last_next;

    always_comb
    begin
        vld_next  = vld_reg;
        data_next = data_reg;
        idx_next  = idx_reg;
        last_next = last_reg;
        if (load)
        begin
            vld_next  = load_val.vld;
            data_next = load_val.data;
            idx_next  = load_val.idx;
            last_next = load_val.last;
        end
        else if (advance)
        begin
            vld_next  = from_up.vld;
            data_next = from_up.data;
            idx_next  = from_up.idx;
            last_next = from_up.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    assign slot = '{vld: vld_reg, data: data_reg, idx: idx_reg, last: last_reg};

endmodule

@@ rtl/icmp_echo_frame_builder.sv @@
// ICMP echo frame builder, top level.
// Holds the configuration registers, the frame image and the 42-cell output chain.
// Depends on iefb_pkg, iefb_image and iefb_cell.

// Each accepted beat with send_request set produces one 42-byte Ethernet/IPv4/ICMP echo
// request frame on the output channel, one byte per beat, byte_index counting 0 to 41 and
// last_byte set on byte 41; a beat with send_request clear produces nothing. The frame is
// built combinationally from the configuration registers and loaded in parallel into a row of
// 42 byte cells; cell 0 drives the output port and every cell hands its byte down the row
// whenever the head beat is taken. A request is accepted when the row holds at most its
// final byte and that byte leaves in the same cycle, so frames follow one another with no
// gap, paced by the single byte per cycle that leaves the head cell when not stalled.
// The first byte appears the cycle after the request is accepted. Configuration
// writes take effect at once and are meant for idle periods.
module icmp_echo_frame_builder (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              cfg_we,
    input  logic [iefb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [iefb_pkg::CFG_W-1:0]        cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              send_request,
    // byte channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        frame_byte,
    output logic [iefb_pkg::IDX_W-1:0]        byte_index,
    output logic                              last_byte
);
    import iefb_pkg::*;

    logic [47:0]  router_mac_reg;
    logic [47:0]  src_mac_reg;
    logic [31:0]  src_ip_reg;
    logic [31:0]  dest_ip_reg;

    frame_t       image;
    cell_t        cells [FRAME_LEN];
    cell_t        load_vals [FRAME_LEN];
    logic [FRAME_LEN-1:0] tail_vld;

    logic         advance;
    logic         chain_free;
    logic         load;

    // Configuration registers; writes to unknown indexes drop silently
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            router_mac_reg <= '0;
            src_mac_reg    <= '0;
            src_ip_reg     <= '0;
            dest_ip_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROUTER_MAC: router_mac_reg <= cfg_data[47:0];
                REG_SRC_MAC:    src_mac_reg    <= cfg_data[47:0];
                REG_SRC_IP:     src_ip_reg     <= cfg_data[31:0];
                REG_DEST_IP:    dest_ip_reg    <= cfg_data[31:0];
                default:        ;
            endcase
        end
    end

    iefb_image u_image (
        .router_mac (router_mac_reg),
        .src_mac    (src_mac_reg),
        .src_ip     (src_ip_reg),
        .dest_ip    (dest_ip_reg),
        .image      (image)
    );

    // Shift the row whenever the head is empty or its beat is taken
    assign advance = !cells[0].vld || !out_stall;

    // Only the head may still hold a byte, and it must leave this cycle
    always_comb
    begin
        tail_vld[0] = 1'b0;
        for (int i = 1; i < FRAME_LEN; i++)
        begin
            tail_vld[i] = cells[i].vld;
        end
    end
    assign chain_free = !(|tail_vld) && advance;

    assign in_stall = !chain_free;
    assign load     = in_valid && chain_free && send_request;

    genvar g;
    generate
        for (g = 0; g < FRAME_LEN; g++)
        begin : g_cell
            assign load_vals[g] = '{vld:  1'b1,
                                    data: image[g],
                                    idx:  IDX_W'(g),
                                    last: (g == FRAME_LEN - 1)};

            if (g == FRAME_LEN - 1)
            begin : g_tail
                iefb_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .load     (load),
                    .advance  (advance),
                    .load_val (load_vals[g]),
                    .from_up  ('0),
                    .slot     (cells[g])
                );
            end
            else
            begin : g_body
                iefb_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .load     (load),
                    .advance  (advance),
                    .load_val (load_vals[g]),
                    .from_up  (cells[g + 1]),
                    .slot     (cells[g])
                );
            end
        end
    endgenerate

    assign out_valid  = cells[0].vld;
    assign frame_byte = cells[0].data;
    assign byte_index = cells[0].idx;
    assign last_byte  = cells[0].last;

    // A frame starts at byte zero the cycle after its request
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && send_request) |=> (out_valid && byte_index == '0))
        else $error("frame did not start at byte zero");

    // Bytes of a frame leave back to back with rising index
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_byte)
            |=> (out_valid && byte_index == $past(byte_index) + 1'b1))
        else $error("frame byte missing or out of order");

    // The end mark sits on the final byte only
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_byte == (byte_index == IDX_W'(FRAME_LEN - 1))))
        else $error("last_byte does not match byte_index");

endmodule
